// ===== rtl/core/sgi_pkg.sv =====
package sgi_pkg;

    localparam int CW   = 32;            // coordinate width
    localparam int FB   = 16;            // fraction bits
    localparam int DW   = CW + 1;        // start point difference
    localparam int PRW  = 2 * CW;        // direction x direction product
    localparam int NPW  = 2 * CW + 1;    // direction x difference product
    localparam int DETW = 2 * CW + 1;    // determinant
    localparam int NUMW = 2 * CW + 2;    // Cramer numerator
    localparam int MW   = NUMW;          // magnitudes
    localparam int RW   = MW + FB;       // scaled dividend
    localparam int XW   = RW + CW + 1;   // trial subtract, with sign
    localparam int EW   = 32;            // epsilon register width
    localparam int QD   = 4;             // queue depth
    localparam int QAW  = $clog2(QD);

    localparam logic [EW-1:0] EPS_RESET = 32'd4295;

    localparam logic [1:0] ST_PARALLEL = 2'd0;
    localparam logic [1:0] ST_HIT      = 2'd1;
    localparam logic [1:0] ST_OUTSIDE  = 2'd2;

    typedef struct packed {
        logic signed [CW-1:0] seg_a_start_x;
        logic signed [CW-1:0] seg_a_start_y;
        logic signed [CW-1:0] seg_a_dir_x;
        logic signed [CW-1:0] seg_a_dir_y;
        logic signed [CW-1:0] seg_b_start_x;
        logic signed [CW-1:0] seg_b_start_y;
        logic signed [CW-1:0] seg_b_dir_x;
        logic signed [CW-1:0] seg_b_dir_y;
    } t_seg_in;

    typedef struct packed {
        logic [1:0]           hit_status;
        logic signed [CW-1:0] t_first;
        logic signed [CW-1:0] t_second;
    } t_seg_out;

    typedef struct packed {
        logic parallel;
        logic inner;
        logic neg1;
        logic neg2;
        logic ovf1;
        logic ovf2;
    } t_flags;

    typedef struct packed {
        t_flags          flags;
        logic [RW-1:0]   num1;
        logic [RW-1:0]   num2;
        logic [MW-1:0]   den;
    } t_job;

endpackage

// ===== rtl/core/sgi_front.sv =====
module sgi_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  sgi_pkg::t_seg_in      i_seg,
    input  logic [sgi_pkg::EW-1:0] i_eps,
    input  logic                  i_full,
    output logic                  o_push,
    output sgi_pkg::t_job         o_job
);
    import sgi_pkg::*;

    logic adv;
    logic r_v1, r_v2, r_v3, r_v4, r_v5;

    // stage 1: directions and start difference
    logic signed [CW-1:0] r_ax, r_ay, r_bx, r_by;
    logic signed [DW-1:0] r_dx, r_dy;
    // stage 2: products
    logic signed [PRW-1:0] r_p_axby, r_p_aybx;
    logic signed [NPW-1:0] r_p_bxdy, r_p_bydx, r_p_axdy, r_p_aydx;
    // stage 3: determinant and numerators
    logic signed [DETW-1:0] r_det;
    logic signed [NUMW-1:0] r_n1, r_n2;
    // stage 4: magnitudes and signs
    logic [MW-1:0] r_det_mag, r_n1_mag, r_n2_mag;
    logic          r_det_neg, r_n1_neg, r_n2_neg, r_det_zero, r_n1_zero, r_n2_zero;
    // stage 5: classified job
    t_job r_job, n_job;
    logic [RW-1:0] num1, num2;

    assign adv     = !r_v5 || !i_full;
    assign o_ready = adv;
    assign o_push  = r_v5 && !i_full;
    assign o_job   = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_comb begin
        num1 = RW'(r_n1_mag) << FB;
        num2 = RW'(r_n2_mag) << FB;
        n_job.flags.parallel = r_det_zero || (r_det_mag < MW'(i_eps));
        n_job.flags.inner    = (r_n1_zero || (r_n1_neg == r_det_neg && r_det_mag >= r_n1_mag))
                            && (r_n2_zero || (r_n2_neg == r_det_neg && r_det_mag >= r_n2_mag));
        n_job.flags.neg1     = r_n1_neg != r_det_neg;
        n_job.flags.neg2     = r_n2_neg != r_det_neg;
        n_job.flags.ovf1     = XW'(num1) >= (XW'(r_det_mag) << CW);
        n_job.flags.ovf2     = XW'(num2) >= (XW'(r_det_mag) << CW);
        n_job.num1           = num1;
        n_job.num2           = num2;
        n_job.den            = r_det_mag;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ax <= i_seg.seg_a_dir_x;
            r_ay <= i_seg.seg_a_dir_y;
            r_bx <= i_seg.seg_b_dir_x;
            r_by <= i_seg.seg_b_dir_y;
            r_dx <= DW'(i_seg.seg_a_start_x) - DW'(i_seg.seg_b_start_x);
            r_dy <= DW'(i_seg.seg_a_start_y) - DW'(i_seg.seg_b_start_y);

            r_p_axby <= PRW'(r_ax) * PRW'(r_by);
            r_p_aybx <= PRW'(r_ay) * PRW'(r_bx);
            r_p_bxdy <= NPW'(r_bx) * NPW'(r_dy);
            r_p_bydx <= NPW'(r_by) * NPW'(r_dx);
            r_p_axdy <= NPW'(r_ax) * NPW'(r_dy);
            r_p_aydx <= NPW'(r_ay) * NPW'(r_dx);

            r_det <= DETW'(r_p_axby) - DETW'(r_p_aybx);
            r_n1  <= NUMW'(r_p_bxdy) - NUMW'(r_p_bydx);
            r_n2  <= NUMW'(r_p_axdy) - NUMW'(r_p_aydx);

            r_det_neg  <= r_det[DETW-1];
            r_n1_neg   <= r_n1[NUMW-1];
            r_n2_neg   <= r_n2[NUMW-1];
            r_det_zero <= r_det == '0;
            r_n1_zero  <= r_n1 == '0;
            r_n2_zero  <= r_n2 == '0;
            r_det_mag  <= r_det[DETW-1] ? MW'(-MW'(r_det)) : MW'(r_det);
            r_n1_mag   <= r_n1[NUMW-1] ? -MW'(r_n1) : MW'(r_n1);
            r_n2_mag   <= r_n2[NUMW-1] ? -MW'(r_n2) : MW'(r_n2);

            r_job <= n_job;
        end
    end

endmodule

// ===== rtl/core/sgi_queue.sv =====
module sgi_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sgi_pkg::t_job i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output sgi_pkg::t_job o_data
);
    import sgi_pkg::*;

    t_job           r_mem [QD];
    logic [QAW-1:0] r_wptr, r_rptr;
    logic [QAW:0]   r_count;

    assign o_full  = r_count == (QAW+1)'(QD);
    assign o_empty = r_count == '0;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wptr <= r_wptr + 1'b1;
            if (i_pop)  r_rptr <= r_rptr + 1'b1;
            r_count <= r_count + (QAW+1)'(i_push) - (QAW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wptr] <= i_data;
    end

endmodule

// ===== rtl/core/sgi_divider.sv =====
module sgi_divider (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [sgi_pkg::RW-1:0] i_num,
    input  logic [sgi_pkg::MW-1:0] i_den,
    output logic [sgi_pkg::CW-1:0] o_quo
);
    import sgi_pkg::*;

    // one restoring step per stage, quotient bit CW-1 first
    logic [RW-1:0] r_rem [CW];
    logic [MW-1:0] r_den [CW];
    logic [CW-1:0] r_quo [CW];

    for (genvar k = 0; k < CW; k++) begin : g_stage
        localparam int BIT = CW - 1 - k;
        logic [RW-1:0] rem_in, n_rem;
        logic [MW-1:0] den_in;
        logic [CW-1:0] quo_in, n_quo;
        logic [XW-1:0] trial;

        if (k == 0) begin : g_first
            assign rem_in = i_num;
            assign den_in = i_den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign den_in = r_den[k-1];
            assign quo_in = r_quo[k-1];
        end

        always_comb begin
            trial      = XW'(rem_in) - (XW'(den_in) << BIT);
            n_rem      = trial[XW-1] ? rem_in : trial[RW-1:0];
            n_quo      = quo_in;
            n_quo[BIT] = !trial[XW-1];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_den[k] <= den_in;
                r_quo[k] <= n_quo;
            end
        end
    end

    assign o_quo = r_quo[CW-1];

endmodule

// ===== rtl/core/sgi_back.sv =====
module sgi_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_vld,
    input  sgi_pkg::t_job     i_job,
    output logic              o_pop,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output sgi_pkg::t_seg_out o_res
);
    import sgi_pkg::*;

    logic          en;
    logic [CW-1:0] r_vld;
    t_flags        r_flg [CW];
    logic [CW-1:0] quo1, quo2;
    t_seg_out      r_out, n_out;
    logic          r_out_vld;

    function automatic logic [CW-1:0] fix_quo(logic [CW-1:0] q, logic neg, logic ovf);
        logic [CW:0] limit;
        logic [CW:0] mag;
        limit = neg ? ((CW+1)'(1) << (CW-1)) : (((CW+1)'(1) << (CW-1)) - 1'b1);
        mag   = (ovf || ({1'b0, q} > limit)) ? limit : {1'b0, q};
        return neg ? CW'(-mag) : CW'(mag);
    endfunction

    assign en          = !r_out_vld || i_res_ready;
    assign o_pop       = en && i_job_vld;
    assign o_res_valid = r_out_vld;
    assign o_res       = r_out;

    sgi_divider u_div1 (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (i_job.num1),
        .i_den (i_job.den),
        .o_quo (quo1)
    );

    sgi_divider u_div2 (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (i_job.num2),
        .i_den (i_job.den),
        .o_quo (quo2)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_vld     <= {r_vld[CW-2:0], i_job_vld};
            r_out_vld <= r_vld[CW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_flg[0] <= i_job.flags;
            for (int k = 1; k < CW; k++) r_flg[k] <= r_flg[k-1];
            r_out <= n_out;
        end
    end

    always_comb begin
        if (r_flg[CW-1].parallel) begin
            n_out.hit_status = ST_PARALLEL;
            n_out.t_first    = '0;
            n_out.t_second   = '0;
        end else begin
            n_out.hit_status = r_flg[CW-1].inner ? ST_HIT : ST_OUTSIDE;
            n_out.t_first    = fix_quo(quo1, r_flg[CW-1].neg1, r_flg[CW-1].ovf1);
            n_out.t_second   = fix_quo(quo2, r_flg[CW-1].neg2, r_flg[CW-1].ovf2);
        end
    end

`ifndef SYNTHESIS
    a_parallel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out.hit_status == ST_PARALLEL |-> r_out.t_first == '0
                                                      && r_out.t_second == '0)
        else $error("parallel result with non-zero parameters");
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> r_out.hit_status == ST_PARALLEL || r_out.hit_status == ST_HIT
                   || r_out.hit_status == ST_OUTSIDE)
        else $error("undefined hit status");
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && r_vld[CW-1] |=> r_out_vld)
        else $error("item lost at divider output");
`endif

endmodule

// ===== rtl/core/segment_intersection_2d.sv =====
// Segment pair intersection, one pair of parametric 2D segments per beat.
// Input channel: i_seg_valid / o_seg_ready carry start point and direction of
// both segments, signed Q16.16. Output channel: o_res_valid / i_res_ready carry
// hit status (parallel, hit, outside) and both segment parameters, Q16.16,
// truncated toward zero and saturated; zero when parallel.
// Configuration: i_cfg_we writes i_cfg_data into the parallel threshold on
// |det|, in units of 2^-32; write it only while the block is idle.
// Throughput: one beat per cycle while i_res_ready is high. From input
// acceptance to result valid a beat passes the five-stage front
// (difference, multipliers, subtract, magnitude, classify), the queue and one
// restoring divider stage per quotient bit in the back, then the output register.
// Reset: synchronous, active low; empties all pipelines and the queue and
// restores the threshold to 4295.
// Stall: while a result waits on i_res_ready, the back end and dividers hold;
// the front accepts until the four-entry queue fills, then drops o_seg_ready.
module segment_intersection_2d (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_seg_valid,
    output logic                   o_seg_ready,
    input  sgi_pkg::t_seg_in       i_seg,
    output logic                   o_res_valid,
    input  logic                   i_res_ready,
    output sgi_pkg::t_seg_out      o_res,
    input  logic                   i_cfg_we,
    input  logic [sgi_pkg::EW-1:0] i_cfg_data
);
    import sgi_pkg::*;

    logic [EW-1:0] r_eps;
    logic          push, pop, full, empty;
    t_job          front_job, head_job;

    // hold the threshold; the user writes it only while idle (not enforced)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= EPS_RESET;
        end else if (i_cfg_we) begin
            r_eps <= i_cfg_data;
        end
    end

    // front: products, determinant, classification and overflow test
    sgi_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_seg_valid),
        .o_ready (o_seg_ready),
        .i_seg   (i_seg),
        .i_eps   (r_eps),
        .i_full  (full),
        .o_push  (push),
        .o_job   (front_job)
    );

    // decouple the two halves so each can stall on its own
    sgi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (head_job)
    );

    // back: two pipelined dividers, saturation and the output register
    sgi_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_vld   (!empty),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res       (o_res)
    );

endmodule

// ===== bench/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sgi_pkg::*;

    localparam int    LATENCY   = CW + 6;
    localparam int    LIMIT_CYC = 2_000_000;
    localparam int    HOLD_LONG = 300;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_seg_valid;
    logic           o_seg_ready;
    t_seg_in        i_seg;
    logic           o_res_valid;
    logic           i_res_ready;
    t_seg_out       o_res;
    logic           i_cfg_we;
    logic [EW-1:0]  i_cfg_data;

    segment_intersection_2d dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_seg_valid (i_seg_valid),
        .o_seg_ready (o_seg_ready),
        .i_seg       (i_seg),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res       (o_res),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    // Bench copy of the threshold, plus pending pairs and expected results
    logic [EW-1:0] eps_shadow;
    t_seg_in       pair_queue[$];
    t_seg_out      hit_queue[$];
    int            send_idle_pct;
    int            recv_idle_pct;
    int            hold_cycles;
    int            errors;
    longint        cycle_count;
    logic          in_taken;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Quotient num/den with FB fraction bits, truncated toward zero, saturated
    function automatic logic signed [CW-1:0] param_of(logic signed [NUMW-1:0] num,
                                                     logic signed [DETW-1:0] den);
        logic              neg;
        logic [NUMW+FB:0]  n_mag;
        logic [NUMW+FB:0]  d_mag;
        logic [NUMW+FB:0]  q;
        logic [NUMW+FB:0]  lim;
        neg   = num[NUMW-1] ^ den[DETW-1];
        n_mag = num[NUMW-1] ? -$signed({{(FB+1){num[NUMW-1]}}, num})
                            : {{(FB+1){1'b0}}, num};
        n_mag = n_mag << FB;
        d_mag = den[DETW-1] ? -$signed({{(NUMW+FB+1-DETW){den[DETW-1]}}, den})
                            : {{(NUMW+FB+1-DETW){1'b0}}, den};
        q     = n_mag / d_mag;
        lim   = (1 << (CW - 1)) - (neg ? 0 : 1);
        if (q > lim) q = lim;
        return neg ? -q[CW-1:0] : q[CW-1:0];
    endfunction

    function automatic logic in_unit(logic signed [NUMW-1:0] num,
                                     logic signed [DETW-1:0] den);
        logic signed [NUMW:0] an;
        logic signed [NUMW:0] ad;
        if (num == 0) return 1'b1;
        if (num[NUMW-1] != den[DETW-1]) return 1'b0;
        an = num < 0 ? -num : num;
        ad = den < 0 ? -den : den;
        return an <= ad;
    endfunction

    function automatic t_seg_out predict_hit(t_seg_in s, logic [EW-1:0] eps);
        t_seg_out               r;
        logic signed [DETW-1:0] det;
        logic signed [DETW:0]   det_mag;
        logic signed [DW-1:0]   dx;
        logic signed [DW-1:0]   dy;
        logic signed [NUMW-1:0] n1;
        logic signed [NUMW-1:0] n2;
        det = s.seg_a_dir_x * s.seg_b_dir_y - s.seg_a_dir_y * s.seg_b_dir_x;
        det_mag = det < 0 ? -det : det;
        dx = s.seg_a_start_x - s.seg_b_start_x;
        dy = s.seg_a_start_y - s.seg_b_start_y;
        r = '0;
        r.hit_status = ST_PARALLEL;
        if (det == 0 || det_mag < $signed({1'b0, eps})) return r;
        n1 = s.seg_b_dir_x * dy - s.seg_b_dir_y * dx;
        n2 = s.seg_a_dir_x * dy - s.seg_a_dir_y * dx;
        r.hit_status = (in_unit(n1, det) && in_unit(n2, det)) ? ST_HIT : ST_OUTSIDE;
        r.t_first  = param_of(n1, det);
        r.t_second = param_of(n2, det);
        return r;
    endfunction

    // Driver: present the head of pair_queue, hold it until accepted
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_seg_valid <= 1'b0;
        end else if (i_seg_valid && !in_taken) begin
            // hold the beat
        end else begin
            if (in_taken) void'(pair_queue.pop_front());
            if (pair_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                i_seg_valid <= 1'b1;
                i_seg       <= pair_queue[0];
            end else begin
                i_seg_valid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure; a long hold-off is counted here
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_res_ready <= 1'b0;
        end else begin
            i_res_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: predict on accepted inputs, check accepted results
    always @(posedge i_clk) begin
        t_seg_out want;
        cycle_count <= cycle_count + 1;
        in_taken    <= i_rst_n && i_seg_valid && o_seg_ready;
        if (i_rst_n && i_seg_valid && o_seg_ready)
            hit_queue.push_back(predict_hit(i_seg, eps_shadow));
        if (i_rst_n && o_res_valid && i_res_ready) begin
            if (hit_queue.size() == 0) begin
                $error("unexpected result beat %p", o_res);
                errors++;
            end else begin
                want = hit_queue.pop_front();
                if (o_res.hit_status !== want.hit_status) begin
                    $error("hit_status expected %0d got %0d", want.hit_status, o_res.hit_status);
                    errors++;
                end
                if (o_res.t_first !== want.t_first) begin
                    $error("t_first expected %0d got %0d", want.t_first, o_res.t_first);
                    errors++;
                end
                if (o_res.t_second !== want.t_second) begin
                    $error("t_second expected %0d got %0d", want.t_second, o_res.t_second);
                    errors++;
                end
            end
        end
        if (cycle_count > LIMIT_CYC) begin
            $display("[segment_intersection_2d] ERROR");
            $finish;
        end
    end

    function automatic logic [CW-1:0] rnd_coord();
        case ($urandom_range(5))
            0:       return $urandom;
            1:       return {$urandom} >> $urandom_range(31);
            2:       return -($urandom_range(1 << 18));
            3:       return $urandom_range(3) << 16;
            4:       return {1'($urandom_range(1)), {(CW-1){$urandom_range(1) == 1}}};
            default: return $signed($urandom_range(1 << 18)) - (1 << 17);
        endcase
    endfunction

    function automatic t_seg_in rnd_pair();
        t_seg_in s;
        logic [CW-1:0] u;
        logic [CW-1:0] v;
        s.seg_a_start_x = rnd_coord();
        s.seg_a_start_y = rnd_coord();
        s.seg_a_dir_x   = rnd_coord();
        s.seg_a_dir_y   = rnd_coord();
        s.seg_b_start_x = rnd_coord();
        s.seg_b_start_y = rnd_coord();
        s.seg_b_dir_x   = rnd_coord();
        s.seg_b_dir_y   = rnd_coord();
        case ($urandom_range(3))
            0: begin
                // crossing inside both: anchor B near A
                u = $urandom_range(1 << 16);
                v = $urandom_range(1 << 16);
                s.seg_a_start_x = $signed($urandom_range(1 << 20)) - (1 << 19);
                s.seg_a_start_y = $signed($urandom_range(1 << 20)) - (1 << 19);
                s.seg_a_dir_x   = $signed($urandom_range(1 << 18)) - (1 << 17);
                s.seg_a_dir_y   = $signed($urandom_range(1 << 18)) - (1 << 17);
                s.seg_b_dir_x   = $signed($urandom_range(1 << 18)) - (1 << 17);
                s.seg_b_dir_y   = $signed($urandom_range(1 << 18)) - (1 << 17);
                s.seg_b_start_x = CW'(64'(s.seg_a_start_x)
                    + ((64'(s.seg_a_dir_x) * 64'($signed({1'b0, u}))) >>> 16)
                    - ((64'(s.seg_b_dir_x) * 64'($signed({1'b0, v}))) >>> 16));
                s.seg_b_start_y = CW'(64'(s.seg_a_start_y)
                    + ((64'(s.seg_a_dir_y) * 64'($signed({1'b0, u}))) >>> 16)
                    - ((64'(s.seg_b_dir_y) * 64'($signed({1'b0, v}))) >>> 16));
            end
            1: begin
                // parallel or nearly so
                s.seg_b_dir_x = s.seg_a_dir_x;
                s.seg_b_dir_y = s.seg_a_dir_y + $signed($urandom_range(2)) - 1;
            end
            default: ;
        endcase
        return s;
    endfunction

    task automatic wait_drained();
        while (pair_queue.size() > 0 || i_seg_valid || hit_queue.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_eps(logic [EW-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        eps_shadow  = val;
    endtask

    task automatic push_pair(logic [CW-1:0] ax, ay, adx, ady, bx, by, bdx, bdy);
        t_seg_in s;
        s = '{ax, ay, adx, ady, bx, by, bdx, bdy};
        pair_queue.push_back(s);
    endtask

    task automatic run_random(int n);
        repeat (n) pair_queue.push_back(rnd_pair());
        wait_drained();
    endtask

    localparam logic [CW-1:0] ONE  = 32'h0001_0000;
    localparam logic [CW-1:0] MAXV = 32'h7FFF_FFFF;
    localparam logic [CW-1:0] MINV = 32'h8000_0000;

    initial begin
        i_rst_n       = 1'b0;
        i_seg_valid   = 1'b0;
        i_seg         = '0;
        i_res_ready   = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_data    = '0;
        eps_shadow    = EPS_RESET;
        errors        = 0;
        cycle_count   = 0;
        hold_cycles   = 0;
        send_idle_pct = 16;
        recv_idle_pct = 83;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: clean cross, touching ends, outside, parallel, extremes
        push_pair(0, 0, ONE, ONE, ONE, 0, -ONE, ONE);
        push_pair(0, 0, ONE, 0, 0, 0, 0, ONE);
        push_pair(0, 0, ONE, 0, ONE, 0, 0, ONE);
        push_pair(0, 0, ONE, 0, 2 * ONE, -ONE, 0, ONE);
        push_pair(0, 0, ONE, 0, -ONE, ONE, 0, -ONE);
        push_pair(0, 0, ONE, ONE, ONE, 0, ONE, ONE);
        push_pair(0, 0, 0, 0, ONE, ONE, ONE, 0);
        push_pair(0, 0, 1, 0, 0, 0, 0, 1);
        push_pair(0, 0, 64, 0, 0, 0, 0, 64);
        push_pair(0, 0, 70, 0, 0, 0, 0, 70);
        push_pair(MAXV, MINV, MAXV, MINV, MINV, MAXV, MINV, MINV);
        push_pair(MINV, MINV, MINV, MINV, MAXV, MAXV, MAXV, MINV);
        push_pair(MAXV, MAXV, 1, 0, MINV, MINV, 0, 1);
        push_pair(MINV, MAXV, MINV, 0, MAXV, MINV, 0, MAXV);
        push_pair('1, '1, '1, '1, 0, 0, '1, 1);
        push_pair(0, 0, ONE, 0, ONE >> 1, -ONE, 0, 2 * ONE);
        wait_drained();

        // Threshold extremes and mid values, each with random traffic
        write_eps(0);
        push_pair(0, 0, ONE, ONE, ONE, 0, ONE, ONE);
        push_pair(0, 0, 1, 0, 0, 0, 0, 1);
        run_random(60);
        write_eps('1);
        run_random(40);
        write_eps(32'd1 << 20);
        run_random(150);

        write_eps(EPS_RESET);
        send_idle_pct = 83;
        recv_idle_pct = 16;
        run_random(150);

        // Long receiver hold-off while the sender keeps offering
        send_idle_pct = 0;
        recv_idle_pct = 0;
        @(negedge i_clk);
        hold_cycles = HOLD_LONG;
        run_random(100);

        write_eps(32'd1);
        run_random(100);

        if (errors == 0) begin
            $display("[segment_intersection_2d] OK");
        end else begin
            $display("[segment_intersection_2d] ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/sgi_pkg.sv
rtl/core/sgi_front.sv
rtl/core/sgi_queue.sv
rtl/core/sgi_divider.sv
rtl/core/sgi_back.sv
rtl/core/segment_intersection_2d.sv
bench/tb.sv
